### rtl/nvds_pkg.sv
// nearest value distance search: shared package
// request and result payload types, request kind codes and the
// command and status structs between controller and datapath
package nvds_pkg;

   // request kind codes
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam int VALUE_W = 32;

   typedef struct packed {
      logic [1:0]         kind;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] distance;
      logic               table_empty;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;      // latch request value as key
      logic clear_count;  // empty the table
      logic search_init;  // lo = 0, hi = count, distances to max
      logic rd_mid;       // read entry at midpoint
      logic search_step;  // narrow lo/hi from midpoint entry
      logic rd_upper;     // read first entry not below key
      logic take_upper;   // upper distance from read data
      logic rd_lower;     // read entry before it
      logic take_lower;   // lower distance from read data
      logic ins_init;     // hole index = count
      logic rd_prev;      // read entry just below the hole
      logic ins_step;     // move entry up or drop key into hole
      logic ins_place;    // drop key into hole at index zero
      logic respond;      // register the result
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic search_done;
      logic has_upper;
      logic has_lower;
      logic prev_above;
      logic idx_zero;
   } status_type;

endpackage

### rtl/nvds_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module nvds_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/nvds_datapath.sv
// nearest value distance search: datapath
// sorted table ram, entry count, search bounds, insert index and result register
// uses nvds_pkg and nvds_ram
module nvds_datapath #(
   parameter int CAPACITY = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  nvds_pkg::cmd_type           cmd,
   input  logic [nvds_pkg::VALUE_W-1:0] req_value,
   output nvds_pkg::status_type        status,
   output nvds_pkg::rsp_type           rsp_data
);
   import nvds_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic [VALUE_W-1:0] up_dist_ff, up_dist_in, lo_dist_ff, lo_dist_in;
   rsp_type            rsp_ff, rsp_in;

   logic [CW-1:0]      mid, lo_m1, idx_m1;
   logic               ram_wr_en, ram_rd_en;
   logic [AW-1:0]      ram_wr_addr, ram_rd_addr;
   logic [VALUE_W-1:0] ram_wr_data, ram_rd_data;

   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_m1  = lo_ff - CW'(1);
   assign idx_m1 = idx_ff - CW'(1);

   // table storage
   nvds_ram #(
      .WIDTH  (VALUE_W),
      .DEPTH  (CAPACITY),
      .ADDR_W (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // read address select
   always_comb begin
      ram_rd_en   = cmd.rd_mid | cmd.rd_upper | cmd.rd_lower | cmd.rd_prev;
      ram_rd_addr = mid[AW-1:0];
      priority if (cmd.rd_upper) begin
         ram_rd_addr = lo_ff[AW-1:0];
      end else if (cmd.rd_lower) begin
         ram_rd_addr = lo_m1[AW-1:0];
      end else if (cmd.rd_prev) begin
         ram_rd_addr = idx_m1[AW-1:0];
      end
   end

   // insert writes: shift an entry up into the hole, or fill the hole with the key
   always_comb begin
      ram_wr_en   = cmd.ins_place | cmd.ins_step;
      ram_wr_addr = idx_ff[AW-1:0];
      ram_wr_data = (cmd.ins_step && status.prev_above) ? ram_rd_data : key_ff;
   end

   // status to controller
   always_comb begin
      status.count_zero  = (count_ff == '0);
      status.count_full  = (count_ff >= CW'(CAPACITY));
      status.search_done = (lo_ff >= hi_ff);
      status.has_upper   = (lo_ff < count_ff);
      status.has_lower   = (lo_ff != '0);
      status.prev_above  = (ram_rd_data > key_ff);
      status.idx_zero    = (idx_ff == '0);
   end

   // next state of the working registers
   always_comb begin
      count_in   = count_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      idx_in     = idx_ff;
      key_in     = key_ff;
      up_dist_in = up_dist_ff;
      lo_dist_in = lo_dist_ff;
      rsp_in     = rsp_ff;

      if (cmd.capture) begin
         key_in = req_value;
      end
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.ins_place || (cmd.ins_step && !status.prev_above)) begin
         count_in = count_ff + CW'(1);
      end

      // binary search for first entry not below key
      if (cmd.search_init) begin
         lo_in      = '0;
         hi_in      = count_ff;
         up_dist_in = '1;
         lo_dist_in = '1;
      end else if (cmd.search_step) begin
         if (ram_rd_data < key_ff) begin
            lo_in = mid + CW'(1);
         end else begin
            hi_in = mid;
         end
      end
      if (cmd.take_upper) begin
         up_dist_in = ram_rd_data - key_ff;
      end
      if (cmd.take_lower) begin
         lo_dist_in = key_ff - ram_rd_data;
      end

      // insert hole walks down from the top
      if (cmd.ins_init) begin
         idx_in = count_ff;
      end else if (cmd.ins_step && status.prev_above) begin
         idx_in = idx_m1;
      end

      // result
      if (cmd.respond) begin
         rsp_in.table_empty = status.count_zero;
         if (status.count_zero) begin
            rsp_in.distance = '0;
         end else begin
            rsp_in.distance = (up_dist_ff < lo_dist_ff) ? up_dist_ff : lo_dist_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      idx_ff     <= idx_in;
      key_ff     <= key_in;
      up_dist_ff <= up_dist_in;
      lo_dist_ff <= lo_dist_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

### rtl/nvds_ctrl.sv
// nearest value distance search: controller
// state machine sequencing load, query and clear requests over the datapath
// uses nvds_pkg
module nvds_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_kind,
   input  nvds_pkg::status_type status,
   output nvds_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);
   import nvds_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_Q_CHECK  = 3'd1;
   localparam logic [2:0] S_Q_COMP   = 3'd2;
   localparam logic [2:0] S_Q_UP     = 3'd3;
   localparam logic [2:0] S_Q_LO     = 3'd4;
   localparam logic [2:0] S_Q_RESP   = 3'd5;
   localparam logic [2:0] S_I_CHECK  = 3'd6;
   localparam logic [2:0] S_I_COMP   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       strobe_ff;
   logic       accept;

   assign accept = start && (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               unique case (req_kind)
                  KIND_LOAD: begin
                     if (!status.count_full) begin
                        cmd.ins_init = 1'b1;
                        state_in     = S_I_CHECK;
                     end
                  end
                  KIND_QUERY: begin
                     if (status.count_zero) begin
                        cmd.respond = 1'b1;
                     end else begin
                        cmd.search_init = 1'b1;
                        state_in        = S_Q_CHECK;
                     end
                  end
                  KIND_CLEAR: cmd.clear_count = 1'b1;
                  default: ;
               endcase
            end
         end
         // search loop: read midpoint, then narrow
         S_Q_CHECK: begin
            if (!status.search_done) begin
               cmd.rd_mid = 1'b1;
               state_in   = S_Q_COMP;
            end else if (status.has_upper) begin
               cmd.rd_upper = 1'b1;
               state_in     = S_Q_UP;
            end else begin
               cmd.rd_lower = 1'b1;
               state_in     = S_Q_LO;
            end
         end
         S_Q_COMP: begin
            cmd.search_step = 1'b1;
            state_in        = S_Q_CHECK;
         end
         // neighbor reads
         S_Q_UP: begin
            cmd.take_upper = 1'b1;
            if (status.has_lower) begin
               cmd.rd_lower = 1'b1;
               state_in     = S_Q_LO;
            end else begin
               state_in = S_Q_RESP;
            end
         end
         S_Q_LO: begin
            cmd.take_lower = 1'b1;
            state_in       = S_Q_RESP;
         end
         S_Q_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         // insert: walk the hole down past larger entries
         S_I_CHECK: begin
            if (status.idx_zero) begin
               cmd.ins_place = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = S_I_COMP;
            end
         end
         S_I_COMP: begin
            cmd.ins_step = 1'b1;
            state_in     = status.prev_above ? S_I_CHECK : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.respond;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

### rtl/nearest_value_distance_search.sv
// Nearest value distance search, top level. Uses nvds_pkg, nvds_ctrl, nvds_datapath.
// Query: busy through the binary search and neighbor reads; each search step reads the midpoint
//   through the registered ram read port, then narrows the bounds. Result strobe is registered.
// Load: busy while the hole walks down, moving each larger entry up, then the key drops in.
// Clear, ignored kinds, loads into a full table and queries on an empty table: busy stays low.
//   Result strobe is one cycle wide, receiver cannot stall. Synchronous reset empties the table.
module nearest_value_distance_search #(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nvds_pkg::req_type req_data,
   output logic              rsp_strobe,
   output nvds_pkg::rsp_type rsp_data
);
   import nvds_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing
   nvds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_kind   (req_data.kind),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // table and arithmetic
   nvds_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_value (req_data.value),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/nvds_checker.sv
// nearest value distance search: port-level checker and its bind
// watches the top level ports only; uses nvds_pkg
module nvds_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input nvds_pkg::req_type req_data,
   input logic              rsp_strobe,
   input nvds_pkg::rsp_type rsp_data
);
   import nvds_pkg::*;

   // empty table always reports zero distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.table_empty |-> rsp_data.distance == '0)
      else $error("empty result with nonzero distance");

   // clear is done by the next cycle, with no result
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.kind == KIND_CLEAR |=> !busy && !rsp_strobe)
      else $error("clear request did not complete in one cycle");

   // query right after a clear sees an empty table
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind == KIND_CLEAR) ##1
      (start && !busy && req_data.kind == KIND_QUERY)
      |=> rsp_strobe && rsp_data.table_empty)
      else $error("query after clear did not report empty table");

   // a result follows either an accepted query or the end of a busy period
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy) ||
                     ($past(start) && $past(req_data.kind) == KIND_QUERY))
      else $error("result without a query");

endmodule

bind nearest_value_distance_search nvds_checker u_nvds_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

### tb/testbench.sv
// testbench for nearest_value_distance_search: directed table, then random requests
// checked against a sorted mirror of the table kept here; depends on nvds_pkg and the rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import nvds_pkg::*;

   localparam int TABLE_DEPTH   = 1024;
   // random requests around the full table fill, which carries most of the load
   localparam int RANDOM_ITEMS  = 60;
   // longest load shifts the whole table
   localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 32;
   localparam int DIRECTED_ROWS = 25;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam bit [VALUE_W-1:0] CORNER_VALUES [6] = '{
      32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
      32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF
   };

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type answer;
   } directed_row_type;

   localparam rsp_type NO_ANSWER = '{32'h0, 1'b0};

   // answers typed in where obvious, the rest come from the mirror
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{'{KIND_QUERY,  32'h0000_0000}, 1'b1, '{32'h0000_0000, 1'b1}},
      '{'{KIND_QUERY,  32'hFFFF_FFFF}, 1'b1, '{32'h0000_0000, 1'b1}},
      '{'{KIND_UNUSED, 32'h0000_0005}, 1'b0, NO_ANSWER},
      '{'{KIND_QUERY,  32'h0000_0007}, 1'b1, '{32'h0000_0000, 1'b1}},
      '{'{KIND_LOAD,   32'h0000_0000}, 1'b0, NO_ANSWER},
      '{'{KIND_QUERY,  32'hFFFF_FFFF}, 1'b1, '{32'hFFFF_FFFF, 1'b0}},
      '{'{KIND_QUERY,  32'h0000_0000}, 1'b1, '{32'h0000_0000, 1'b0}},
      '{'{KIND_LOAD,   32'hFFFF_FFFF}, 1'b0, NO_ANSWER},
      '{'{KIND_QUERY,  32'h7FFF_FFFF}, 1'b0, NO_ANSWER},
      '{'{KIND_QUERY,  32'h8000_0000}, 1'b0, NO_ANSWER},
      '{'{KIND_LOAD,   32'd1000},      1'b0, NO_ANSWER},
      '{'{KIND_LOAD,   32'd1000},      1'b0, NO_ANSWER},
      '{'{KIND_QUERY,  32'd1000},      1'b1, '{32'h0000_0000, 1'b0}},
      '{'{KIND_QUERY,  32'd999},       1'b0, NO_ANSWER},
      '{'{KIND_LOAD,   32'd500},       1'b0, NO_ANSWER},
      '{'{KIND_QUERY,  32'd750},       1'b0, NO_ANSWER},
      '{'{KIND_QUERY,  32'hFFFF_FFFE}, 1'b0, NO_ANSWER},
      '{'{KIND_CLEAR,  32'h0000_0000}, 1'b0, NO_ANSWER},
      '{'{KIND_QUERY,  32'd1000},      1'b1, '{32'h0000_0000, 1'b1}},
      '{'{KIND_LOAD,   32'd42},        1'b0, NO_ANSWER},
      '{'{KIND_QUERY,  32'd40},        1'b0, NO_ANSWER},
      '{'{KIND_UNUSED, 32'hFFFF_FFFF}, 1'b0, NO_ANSWER},
      '{'{KIND_QUERY,  32'h0000_0000}, 1'b0, NO_ANSWER},
      '{'{KIND_LOAD,   32'h5555_5555}, 1'b0, NO_ANSWER},
      '{'{KIND_QUERY,  32'hAAAA_AAAA}, 1'b0, NO_ANSWER}
   };

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // sorted copy of the table and the distances still owed
   bit [VALUE_W-1:0] mirror_values [$];
   rsp_type          owed_distances [$];

   // driver side view of the table fill
   int               sent_fill;
   bit [VALUE_W-1:0] recent_loads [$];

   int requests_sent;
   int requests_accepted;
   int distances_checked;
   int loads_dropped;
   int mismatch_count;

   nearest_value_distance_search #(
      .CAPACITY(TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5ns clock = ~clock;

   // first mirror index whose entry is >= key, or > key when past_equal is set
   function automatic int mirror_bound(bit [VALUE_W-1:0] key, bit past_equal);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = mirror_values.size();
      while (lo < hi) begin
         mid = lo + ((hi - lo) >> 1);
         if (mirror_values[mid] < key || (past_equal && mirror_values[mid] == key))
            lo = mid + 1;
         else
            hi = mid;
      end
      return lo;
   endfunction

   // apply one request to the mirror, returns 1 when it owes a distance
   function automatic bit predict_distance(input req_type r, output rsp_type ans);
      int               nxt;
      bit [VALUE_W-1:0] best;
      bit [VALUE_W-1:0] gap;
      ans = '0;
      case (r.kind)
         KIND_LOAD: begin
            if (mirror_values.size() >= TABLE_DEPTH) begin
               loads_dropped++;
            end else begin
               mirror_values.insert(mirror_bound(r.value, 1'b1), r.value);
            end
            return 1'b0;
         end
         KIND_CLEAR: begin
            mirror_values.delete();
            return 1'b0;
         end
         KIND_QUERY: begin
            if (mirror_values.size() == 0) begin
               ans.distance    = '0;
               ans.table_empty = 1'b1;
               return 1'b1;
            end
            nxt  = mirror_bound(r.value, 1'b0);
            best = '1;
            if (nxt < mirror_values.size())
               best = mirror_values[nxt] - r.value;
            if (nxt > 0) begin
               gap = r.value - mirror_values[nxt - 1];
               if (gap < best)
                  best = gap;
            end
            ans.distance    = best;
            ans.table_empty = 1'b0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // watch both sides at each rising edge, values seen are the settled ones
   always @(posedge clock) begin
      rsp_type want;
      rsp_type predicted;
      if (!reset) begin
         // results first: one arriving now belongs to an older query
         if (rsp_strobe) begin
            if (owed_distances.size() == 0) begin
               $error("result with no query outstanding: distance %h table_empty %b",
                      rsp_data.distance, rsp_data.table_empty);
               mismatch_count++;
            end else begin
               want = owed_distances.pop_front();
               if (rsp_data.distance !== want.distance) begin
                  $error("distance: expected %h, actual %h", want.distance,
                         rsp_data.distance);
                  mismatch_count++;
               end
               if (rsp_data.table_empty !== want.table_empty) begin
                  $error("table_empty: expected %b, actual %b", want.table_empty,
                         rsp_data.table_empty);
                  mismatch_count++;
               end
               distances_checked++;
            end
         end
         // accepted request
         if (start && !busy) begin
            if (predict_distance(req_data, predicted)) begin
               if (requests_accepted < DIRECTED_ROWS && DIRECTED[requests_accepted].typed)
                  predicted = DIRECTED[requests_accepted].answer;
               owed_distances.push_back(predicted);
            end
            requests_accepted++;
         end
      end
   end

   // offer one request, with random idle cycles ahead of it
   task automatic send_request(input req_type r, input int idle_pct);
      req_type junk;
      while ($urandom_range(99) < idle_pct) begin
         junk.kind  = 2'($urandom());
         junk.value = $urandom();
         start    <= 1'b0;
         req_data <= junk;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      requests_sent++;
      // track the fill so random requests keep loads short
      if (r.kind == KIND_LOAD && sent_fill < TABLE_DEPTH) begin
         sent_fill++;
         recent_loads.push_back(r.value);
         if (recent_loads.size() > 16)
            void'(recent_loads.pop_front());
      end else if (r.kind == KIND_CLEAR) begin
         sent_fill = 0;
      end
   endtask

   // values that hit corners, duplicates and near misses
   function automatic bit [VALUE_W-1:0] random_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 25 || (pick >= 58 && recent_loads.size() == 0))
         return $urandom();
      if (pick < 45)
         return $urandom_range(63, 0);
      if (pick < 58)
         return CORNER_VALUES[$urandom_range(5, 0)];
      return recent_loads[$urandom_range(recent_loads.size() - 1, 0)]
             + 32'($urandom_range(8, 0)) - 32'd4;
   endfunction

   // mostly loads and queries on a small table, some clears and unused kinds
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (sent_fill >= 64 || (sent_fill >= 40 && pick < 25) || pick < 5)
         r.kind = KIND_CLEAR;
      else if (pick < 9)
         r.kind = KIND_UNUSED;
      else if (pick < 55)
         r.kind = KIND_LOAD;
      else
         r.kind = KIND_QUERY;
      r.value = (r.kind == KIND_UNUSED) ? 32'($urandom()) : random_value();
      return r;
   endfunction

   // fill the table in non-descending order, then hit it while full
   task automatic fill_to_capacity(input int idle_pct);
      bit [VALUE_W-1:0] level;
      bit [VALUE_W-1:0] step;
      send_request('{KIND_CLEAR, 32'h0}, idle_pct);
      level = $urandom_range(15, 0);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         send_request('{KIND_LOAD, level}, idle_pct);
         if (i % 128 == 127)
            send_request('{KIND_QUERY, 32'($urandom())}, idle_pct);
         step = ($urandom_range(3, 0) == 0) ? 32'h0 : 32'($urandom_range(1 << 21, 1));
         level = (level > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : level + step;
      end
      // loads into a full table are dropped
      send_request('{KIND_LOAD, 32'h0000_0000}, idle_pct);
      send_request('{KIND_LOAD, 32'hFFFF_FFFF}, idle_pct);
      send_request('{KIND_LOAD, 32'($urandom())}, idle_pct);
      send_request('{KIND_QUERY, 32'h0000_0000}, idle_pct);
      send_request('{KIND_QUERY, 32'hFFFF_FFFF}, idle_pct);
      send_request('{KIND_QUERY, level}, idle_pct);
      repeat (5) send_request('{KIND_QUERY, 32'($urandom())}, idle_pct);
      send_request('{KIND_CLEAR, 32'h0}, idle_pct);
   endtask

   // main sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_request(DIRECTED[i].req, 14);

      // sender gaps 14 percent, then 48, then none
      repeat (RANDOM_ITEMS / 3) send_request(random_request(), 14);
      fill_to_capacity(14);
      repeat (RANDOM_ITEMS / 3) send_request(random_request(), 48);
      repeat (RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3)) send_request(random_request(), 0);
      start <= 1'b0;

      // drain, then watch for stray results
      while (owed_distances.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests incl. one full table, %0d distances checked",
               requests_sent, distances_checked);
      $display("loads dropped on a full table: %0d, mismatches: %0d",
               loads_dropped, mismatch_count);
      if (mismatch_count == 0 && owed_distances.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // hang guard
   initial begin
      #10ms;
      $display("timeout with %0d distances outstanding", owed_distances.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
